FILE: hdl/mbrsp_pkg.sv
// Shared types and constants for the rotating bitmap store.
package mbrsp_pkg;

	localparam int LANES = 8;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_WIDTH = 2'd2;

	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_ROWS   = 2'd1;
	localparam logic [1:0] REG_SHIFT_COLS = 2'd2;
	localparam logic [1:0] REG_PAD_ROWS   = 2'd3;

	localparam logic [6:0] SRC_WIDTH_RST = 7'd8;
	localparam logic [6:0] SRC_ROWS_RST  = 7'd8;

	// per-lane control at the accept edge
	typedef struct packed {
		logic       wr;
		logic       hit;
		logic [2:0] pos;
	} lane_ctl_t;

	// per-lane result after the memory read
	typedef struct packed {
		logic       pix;
		logic [2:0] pos;
	} lane_out_t;

endpackage

FILE: hdl/mbrsp_if.sv
// Request and response channel interfaces.
interface mbrsp_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [6:0] row;
	logic [3:0] byte_index;
	logic [7:0] data_in;

	modport source (output valid, cmd, row, byte_index, data_in, input ready);
	modport sink (input valid, cmd, row, byte_index, data_in, output ready);
endinterface

interface mbrsp_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic [1:0] status;

	modport source (output valid, data_out, status, input ready);
	modport sink (input valid, data_out, status, output ready);
endinterface

FILE: hdl/mbrsp_lane.sv
// One lane: stores the source rows whose index mod 8 equals this lane.
module mbrsp_lane #(
	parameter int LDEPTH = 8,
	parameter int AW     = 3,
	parameter int BW     = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   acc,
	input  mbrsp_pkg::lane_ctl_t   ctl,
	input  logic [AW-1:0]          waddr,
	input  logic [BW-1:0]          wbyte,
	input  logic [7:0]             wdata,
	input  logic [7:0]             wmask,
	input  logic [AW-1:0]          raddr,
	input  logic [BW+2:0]          rcol,
	output mbrsp_pkg::lane_out_t   lane_o
);
	import mbrsp_pkg::*;

	localparam int EW = (1 << BW) * 8;

	logic [EW-1:0]   mem [LDEPTH];
	logic [LDEPTH-1:0] vld_q;
	logic [EW-1:0]   wfull;
	logic [EW-1:0]   rword_s1;
	logic            rvld_s1;
	logic            hit_s1;
	logic [2:0]      pos_s1;
	logic [BW+2:0]   col_s1;

	// fresh entry: everything else zero
	always_comb begin
		wfull = '0;
		for (int k = 0; k < 8; k++) begin
			wfull[{wbyte, 3'(k)}] = wdata[k] & wmask[k];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ctl.wr) begin
			if (!vld_q[waddr]) begin
				mem[waddr] <= wfull;
			end else begin
				for (int k = 0; k < 8; k++) begin
					if (wmask[k]) begin
						mem[waddr][{wbyte, 3'(k)}] <= wdata[k];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (acc && ctl.wr) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rword_s1 <= mem[raddr];
			rvld_s1  <= vld_q[raddr];
			pos_s1   <= ctl.pos;
			col_s1   <= rcol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s1 <= 1'b0;
		end else if (acc) begin
			hit_s1 <= ctl.hit;
		end
	end

	assign lane_o.pix = hit_s1 & rvld_s1 & rword_s1[col_s1];
	assign lane_o.pos = pos_s1;

endmodule

FILE: hdl/mbrsp_merge.sv
// Merge stage: packs lane pixels into the output byte and holds the response word.
module mbrsp_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbrsp_pkg::lane_out_t lane_o [mbrsp_pkg::LANES],
	input  logic                 valid_s1,
	input  logic [1:0]           status_s1,
	output logic                 advance,
	mbrsp_rsp_if.source          rsp
);
	import mbrsp_pkg::*;

	logic [7:0] byte_d;
	logic [7:0] data_q;
	logic [1:0] status_q;
	logic       valid_q;

	always_comb begin
		byte_d = '0;
		for (int l = 0; l < LANES; l++) begin
			if (lane_o[l].pix) begin
				byte_d[3'd7 - lane_o[l].pos] = 1'b1;
			end
		end
	end

	assign advance = !valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			data_q   <= byte_d;
			status_q <= status_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= valid_s1;
		end
	end

	assign rsp.valid    = valid_q;
	assign rsp.data_out = data_q;
	assign rsp.status   = status_q;

endmodule

FILE: hdl/mono_bitmap_rotate_shift_pad.sv
// Top level of the monochrome bitmap store with rotate, column shift and padding.
//
// Takes one word per clock unless the response side stalls, and returns one response word
// per request via the lane and merge registers. Source rows are spread over eight lanes by
// row mod 8, each lane a small memory of full source rows with one read port, so a read
// fetches its eight rotated pixels in one access and a write stores one byte into one lane.
// The store reads as zero after reset through per-row valid bits; there is no clearing pass.
module mono_bitmap_rotate_shift_pad #(
	parameter int MAX_SRC_WIDTH = 64,
	parameter int MAX_SRC_ROWS  = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [6:0] cfg_data,
	mbrsp_req_if.sink  req,
	mbrsp_rsp_if.source rsp
);
	import mbrsp_pkg::*;

	localparam int WBYTES = (MAX_SRC_WIDTH + 7) / 8;
	localparam int LDEPTH = (MAX_SRC_ROWS + 7) / 8;
	localparam int BW     = (WBYTES > 1) ? $clog2(WBYTES) : 1;
	localparam int AW     = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

	logic [6:0]        src_width_q;
	logic [6:0]        src_rows_q;
	logic signed [6:0] shift_q;
	logic [5:0]        pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q <= SRC_WIDTH_RST;
			src_rows_q  <= SRC_ROWS_RST;
			shift_q     <= '0;
			pad_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SRC_WIDTH:  src_width_q <= cfg_data;
				REG_SRC_ROWS:   src_rows_q  <= cfg_data;
				REG_SHIFT_COLS: shift_q     <= cfg_data;
				REG_PAD_ROWS:   pad_q       <= cfg_data[5:0];
				default:        src_width_q <= src_width_q;
			endcase
		end
	end

	logic [6:0] w_eff;
	logic [6:0] h_eff;

	always_comb begin
		if (src_width_q == '0) begin
			w_eff = 7'd1;
		end else if ({2'b00, src_width_q} > 9'(MAX_SRC_WIDTH)) begin
			w_eff = 7'(MAX_SRC_WIDTH);
		end else begin
			w_eff = src_width_q;
		end
		if (src_rows_q == '0) begin
			h_eff = 7'd1;
		end else if ({2'b00, src_rows_q} > 9'(MAX_SRC_ROWS)) begin
			h_eff = 7'(MAX_SRC_ROWS);
		end else begin
			h_eff = src_rows_q;
		end
	end

	// geometry checks
	logic signed [8:0] ow;
	logic [7:0]        orows;
	logic [6:0]        col0;
	logic [1:0]        status_d;
	logic              rd_data;

	assign ow    = $signed({2'b00, h_eff}) + $signed({{2{shift_q[6]}}, shift_q});
	assign orows = {1'b0, w_eff} + {2'b00, pad_q};
	assign col0  = {req.byte_index, 3'b000};

	always_comb begin
		status_d = ST_OK;
		if (req.cmd == CMD_WRITE) begin
			if (req.row >= h_eff || col0 >= w_eff) begin
				status_d = ST_RANGE;
			end
		end else if (ow <= 9'sd0) begin
			status_d = ST_WIDTH;
		end else if ({1'b0, req.row} >= orows || $signed({2'b00, col0}) >= ow) begin
			status_d = ST_RANGE;
		end
	end

	assign rd_data = (req.cmd == CMD_READ) && (status_d == ST_OK) && (req.row < w_eff);

	// source row feeding output bit k is base - k
	logic signed [9:0] base;
	assign base = $signed({3'b000, h_eff}) - 10'sd1 + $signed({{3{shift_q[6]}}, shift_q})
		- $signed({3'b000, col0});

	// handshake and first stage
	logic       advance;
	logic       valid_s1;
	logic [1:0] status_s1;
	logic       acc;

	assign req.ready = !valid_s1 || advance;
	assign acc       = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
		end
	end

	// write byte, bit-reversed so stored bit index equals column
	logic [7:0] wdata;
	logic [7:0] wmask;
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			wdata[k] = req.data_in[7 - k];
			wmask[k] = {req.byte_index, 3'(k)} < w_eff;
		end
	end

	logic      wr_ok;
	lane_out_t lane_o [LANES];
	logic [LANES-1:0] lane_wr;

	assign wr_ok = (req.cmd == CMD_WRITE) && (status_d == ST_OK);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [2:0]        k_l;
		logic signed [9:0] sr_l;
		logic [7:0]        c_l;
		lane_ctl_t         ctl;

		assign k_l  = base[2:0] - 3'(l);
		assign sr_l = base - $signed({7'b0000000, k_l});
		assign c_l  = {1'b0, col0} + {5'b00000, k_l};

		assign ctl.wr  = wr_ok && (req.row[2:0] == 3'(l));
		assign ctl.pos = k_l;
		assign ctl.hit = rd_data && ($signed({1'b0, c_l}) < ow) && !sr_l[9]
			&& (sr_l < $signed({3'b000, h_eff}));
		assign lane_wr[l] = ctl.wr;

		mbrsp_lane #(
			.LDEPTH(LDEPTH),
			.AW    (AW),
			.BW    (BW)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.acc   (acc),
			.ctl   (ctl),
			.waddr (AW'(req.row[6:3])),
			.wbyte (BW'(req.byte_index)),
			.wdata (wdata),
			.wmask (wmask),
			.raddr (AW'(sr_l[9:3])),
			.rcol  ((BW + 3)'(req.row)),
			.lane_o(lane_o[l])
		);
	end

	mbrsp_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.lane_o   (lane_o),
		.valid_s1 (valid_s1),
		.status_s1(status_s1),
		.advance  (advance),
		.rsp      (rsp)
	);

	// a write lands in at most one lane
	a_one_lane_wr: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(lane_wr))
		else $error("write hits more than one lane");

	// a stalled first stage keeps its word
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("first stage word dropped under stall");

	// error responses carry no pixels
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.data_out == 8'h00)
		else $error("error response with nonzero data");

endmodule

FILE: tb/tb_mono_bitmap_rotate_shift_pad.sv
// Self-checking testbench for the rotating glyph store: directed edge cases, then random traffic.
module tb_mono_bitmap_rotate_shift_pad;
	import mbrsp_pkg::*;

	localparam int MAX_W       = 64;
	localparam int MAX_R       = 64;
	localparam int ITEM_TARGET = 650;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       cmd;
		logic [6:0] row;
		logic [3:0] byte_index;
		logic [7:0] data_in;
	} access_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic [1:0] status;
	} reply_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_idx;
	logic [6:0] cfg_data;

	mbrsp_req_if req_ch ();
	mbrsp_rsp_if rsp_ch ();

	mono_bitmap_rotate_shift_pad #(
		.MAX_SRC_WIDTH(MAX_W),
		.MAX_SRC_ROWS (MAX_R)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	access_t access_backlog[$];
	reply_t  reply_forecast[$];

	// shadow of the block: stored pixels by [source column][source row], plus geometry
	logic [MAX_R-1:0] glyph_cols [MAX_W];
	int cur_width = SRC_WIDTH_RST;
	int cur_rows  = SRC_ROWS_RST;
	int cur_shift = 0;
	int cur_pad   = 0;

	// geometry the stimulus was built for
	int plan_width = SRC_WIDTH_RST;
	int plan_rows  = SRC_ROWS_RST;
	int plan_shift = 0;
	int plan_pad   = 0;

	logic burst;
	int   fail_count  = 0;
	int   cycle_count = 0;
	int   send_wait;
	int   rsp_stall;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_dim(input int v, input int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic forecast_reply(input access_t a, output reply_t r);
		int w, h, ow, orows, row, bi, col, c, rc;
		w = clamp_dim(cur_width, MAX_W);
		h = clamp_dim(cur_rows, MAX_R);
		row = a.row;
		bi = a.byte_index;
		r.data_out = '0;
		r.status = ST_OK;
		if (a.cmd == CMD_WRITE) begin
			if (row >= h || bi >= (w + 7) / 8) begin
				r.status = ST_RANGE;
			end else begin
				for (int k = 0; k < 8; k++) begin
					col = bi * 8 + k;
					if (col < w)
						glyph_cols[col][row] = a.data_in[7-k];
				end
			end
		end else begin
			ow = h + cur_shift;
			orows = w + cur_pad;
			if (ow <= 0) begin
				r.status = ST_WIDTH;
			end else if (row >= orows || bi >= (ow + 7) / 8) begin
				r.status = ST_RANGE;
			end else if (row < w) begin
				// output row is a source column; output column c maps back to source row h-1-rc
				for (int k = 0; k < 8; k++) begin
					c = bi * 8 + k;
					rc = c - cur_shift;
					if (c < ow && rc >= 0 && rc < h && glyph_cols[row][h-1-rc])
						r.data_out[7-k] = 1'b1;
				end
			end
		end
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// request driver: per-word gap drawn when the word goes out
	always @(posedge clk) begin : drive_req
		access_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= CMD_WRITE;
			req_ch.row <= '0;
			req_ch.byte_index <= '0;
			req_ch.data_in <= '0;
			send_wait <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
			// hold the word until taken
		end else if (send_wait != 0) begin
			req_ch.valid <= 1'b0;
			send_wait <= send_wait - 1;
		end else if (access_backlog.size() != 0) begin
			nxt = access_backlog.pop_front();
			req_ch.valid <= 1'b1;
			req_ch.cmd <= nxt.cmd;
			req_ch.row <= nxt.row;
			req_ch.byte_index <= nxt.byte_index;
			req_ch.data_in <= nxt.data_in;
			send_wait <= burst ? 0 : $urandom_range(0, 19);
		end else begin
			req_ch.valid <= 1'b0;
		end
	end

	// shadow config, prediction on accept, response check and response stalls
	always @(posedge clk) begin : watch
		reply_t want, got;
		int stall;
		if (!arst_n) begin
			for (int i = 0; i < MAX_W; i++)
				glyph_cols[i] = '0;
			cur_width = SRC_WIDTH_RST;
			cur_rows = SRC_ROWS_RST;
			cur_shift = 0;
			cur_pad = 0;
			rsp_ch.ready <= 1'b0;
			rsp_stall <= 3;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SRC_WIDTH: cur_width = cfg_data;
					REG_SRC_ROWS: cur_rows = cfg_data;
					REG_SHIFT_COLS: cur_shift = $signed(cfg_data);
					REG_PAD_ROWS: cur_pad = cfg_data[5:0];
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				forecast_reply({req_ch.cmd, req_ch.row, req_ch.byte_index, req_ch.data_in}, want);
				reply_forecast.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.data_out = rsp_ch.data_out;
				got.status = rsp_ch.status;
				if (reply_forecast.size() == 0) begin
					$error("unexpected response word: data_out %02h status %0d",
						got.data_out, got.status);
					fail_count++;
				end else begin
					want = reply_forecast.pop_front();
					if (got.data_out !== want.data_out) begin
						$error("data_out: expected %02h, got %02h", want.data_out, got.data_out);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
				end
				if (burst) begin
					rsp_ch.ready <= 1'b1;
				end else begin
					// a zero draw keeps ready up for the next word
					stall = $urandom_range(0, 19);
					rsp_stall <= stall;
					rsp_ch.ready <= (stall == 0);
				end
			end else if (!rsp_ch.ready) begin
				if (rsp_stall <= 1)
					rsp_ch.ready <= 1'b1;
				rsp_stall <= rsp_stall - 1;
			end
		end
	end

	task automatic queue_access(input logic cmd, input int row, input int bi, input int din);
		access_t a;
		a.cmd = cmd;
		a.row = 7'(row);
		a.byte_index = 4'(bi);
		a.data_in = 8'(din);
		access_backlog.push_back(a);
	endtask

	// checked at the falling edge so every nonblocking update has landed
	task automatic wait_drained();
		while (access_backlog.size() != 0 || req_ch.valid || reply_forecast.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic program_geometry(input int w, input int r, input int s, input int p);
		plan_width = w;
		plan_rows = r;
		plan_shift = s;
		plan_pad = p;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SRC_WIDTH;
		cfg_data <= 7'(w);
		@(posedge clk);
		cfg_idx <= REG_SRC_ROWS;
		cfg_data <= 7'(r);
		@(posedge clk);
		cfg_idx <= REG_SHIFT_COLS;
		cfg_data <= 7'(s);
		@(posedge clk);
		cfg_idx <= REG_PAD_ROWS;
		cfg_data <= 7'(p);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_batch(input int n);
		int w, h, ow, orows, pick;
		w = clamp_dim(plan_width, MAX_W);
		h = clamp_dim(plan_rows, MAX_R);
		ow = h + plan_shift;
		orows = w + plan_pad;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				queue_access(CMD_WRITE, $urandom_range(0, h - 1),
					$urandom_range(0, (w + 7) / 8 - 1), $urandom);
			end else if (pick < 80 && ow > 0) begin
				queue_access(CMD_READ, $urandom_range(0, orows - 1),
					$urandom_range(0, (ow + 7) / 8 - 1), $urandom);
			end else if (pick < 90) begin
				// just past the edge of the geometry
				if ($urandom_range(0, 1))
					queue_access(CMD_WRITE, $urandom_range(0, 1) ? h : 0,
						(w + 7) / 8, $urandom);
				else if (ow > 0 && (ow + 7) / 8 < 16 && $urandom_range(0, 1))
					queue_access(CMD_READ, 0, (ow + 7) / 8, $urandom);
				else
					queue_access(CMD_READ, orows, 0, $urandom);
			end else begin
				queue_access(1'($urandom_range(0, 1)), $urandom_range(0, 127),
					$urandom_range(0, 15), $urandom);
			end
		end
	endtask

	initial begin : stimulus
		int sent, n, w, r, s, p;
		cfg_we = 1'b0;
		cfg_idx = REG_SRC_WIDTH;
		cfg_data = '0;
		burst = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset geometry 8x8: in-range, out-of-range rows and bytes, data extremes
		queue_access(CMD_WRITE, 0, 0, 8'hFF);
		queue_access(CMD_WRITE, 7, 0, 8'h81);
		queue_access(CMD_WRITE, 3, 0, 8'h00);
		queue_access(CMD_WRITE, 8, 0, 8'hAA);
		queue_access(CMD_WRITE, 0, 1, 8'h55);
		queue_access(CMD_READ, 0, 0, 8'h00);
		queue_access(CMD_READ, 7, 0, 8'hFF);
		queue_access(CMD_READ, 8, 0, 8'h00);
		queue_access(CMD_READ, 0, 1, 8'h00);
		wait_drained();

		// width clamps up to 1, rows clamp down to max, shift of -64 leaves no output width
		program_geometry(0, 127, -64, 63);
		queue_access(CMD_READ, 0, 0, 8'h00);
		queue_access(CMD_WRITE, 63, 0, 8'hFF);
		queue_access(CMD_WRITE, 64, 0, 8'h01);
		queue_access(CMD_WRITE, 0, 1, 8'hFF);
		wait_drained();

		// widest source, single row, largest right shift
		program_geometry(127, 0, 63, 0);
		queue_access(CMD_WRITE, 0, 7, 8'hFF);
		queue_access(CMD_WRITE, 1, 0, 8'hFF);
		queue_access(CMD_READ, 63, 7, 8'h00);
		queue_access(CMD_READ, 64, 0, 8'h00);
		queue_access(CMD_READ, 127, 15, 8'hFF);
		queue_access(CMD_READ, 0, 8, 8'h00);
		wait_drained();

		// partial bytes: dropped write bits, pad rows, bits past the output width
		program_geometry(13, 20, -5, 5);
		queue_access(CMD_WRITE, 19, 1, 8'hFF);
		queue_access(CMD_WRITE, 0, 1, 8'hA5);
		queue_access(CMD_READ, 12, 0, 8'h00);
		queue_access(CMD_READ, 12, 1, 8'h00);
		queue_access(CMD_READ, 15, 0, 8'h00);
		queue_access(CMD_READ, 17, 1, 8'h00);
		wait_drained();
		sent = 25;

		while (sent < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: w = $urandom_range(0, 1) ? 127 : $urandom_range(0, 1);
				default: w = $urandom_range(1, MAX_W);
			endcase
			case ($urandom_range(0, 3))
				0: r = $urandom_range(0, 1) ? 64 : $urandom_range(0, 1);
				default: r = $urandom_range(1, MAX_R);
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					case ($urandom_range(0, 3))
						0: s = -64;
						1: s = -63;
						2: s = 63;
						default: s = 0;
					endcase
				end
				3, 4, 5, 6: s = $urandom_range(0, 16) - 8;
				default: s = $urandom_range(0, 127) - 64;
			endcase
			case ($urandom_range(0, 3))
				0: p = $urandom_range(0, 1) ? 63 : 0;
				default: p = $urandom_range(0, 63);
			endcase
			program_geometry(w, r, s, p);
			burst = ($urandom_range(0, 3) == 0);
			n = $urandom_range(20, 70);
			queue_batch(n);
			sent += n;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && reply_forecast.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/mbrsp_pkg.sv
hdl/mbrsp_if.sv
hdl/mbrsp_lane.sv
hdl/mbrsp_merge.sv
hdl/mono_bitmap_rotate_shift_pad.sv
tb/tb_mono_bitmap_rotate_shift_pad.sv
